@@ rtl/core/pbri_pkg.sv @@
// pbri_pkg: shared types, constants and helpers for the sound chip bus register interface
// no dependencies; imported by pbri_exec, the top module and the bench

package pbri_pkg;

    // register file geometry
    localparam int REG_COUNT = 16;
    localparam int IDX_W     = $clog2(REG_COUNT);

    localparam logic [7:0]       REG_LIMIT   = 8'(REG_COUNT);
    localparam logic [IDX_W-1:0] PORT_A_IDX  = IDX_W'(14);
    localparam logic [IDX_W-1:0] PORT_B_IDX  = IDX_W'(15);
    localparam logic [IDX_W-1:0] SOUND_COUNT = IDX_W'(14);

    localparam logic [7:0] PORT_A_RESET = 8'hFF;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;
    localparam logic [2:0] WAIT_STATES  = 3'd4;

    // access kinds and offsets
    localparam logic       CMD_READ   = 1'b0;
    localparam logic       CMD_WRITE  = 1'b1;
    localparam logic [1:0] OFF_SELECT = 2'd0;

    // port A bit positions
    localparam int STROBE_BIT = 5;
    localparam int DSP_BIT    = 4;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRINTER = 2'd0,
        CFG_JOY1    = 2'd1,
        CFG_JOY2    = 2'd2,
        CFG_DSP     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic printer_enable;
        logic joy_port1_enable;
        logic joy_port2_enable;
        logic dsp_report_enable;
    } cfg_t;

    // one bus access
    typedef struct packed {
        logic       command;
        logic [1:0] addr_offset;
        logic       byte_access;
        logic [7:0] write_data;
        logic       new_instruction;
        logic       is_movem;
        logic [7:0] joy1_data;
        logic [7:0] joy2_data;
    } req_t;

    // one access result
    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] wait_cycles;
        logic       sound_write;
        logic [3:0] sound_reg;
        logic [7:0] sound_value;
        logic       printer_valid;
        logic [7:0] printer_byte;
        logic       port_a_written;
        logic [2:0] drive_side_old;
        logic [2:0] drive_side_new;
        logic       dsp_rst_req;
    } rsp_t;

    // register file write request
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } wr_t;

    // side info captured with the register file read
    typedef struct packed {
        logic       fwd_hit;
        logic [7:0] fwd_data;
        logic       entry_valid;
    } look_t;

    // clears the unused bits per register in a written value
    function automatic logic [7:0] mask_value(input logic [IDX_W-1:0] sel,
                                              input logic [7:0] v);
        logic [7:0] r;
        r = v;
        case (sel)
            IDX_W'(1), IDX_W'(3), IDX_W'(5), IDX_W'(13): r = v & 8'h0F;
            IDX_W'(6), IDX_W'(8), IDX_W'(9), IDX_W'(10): r = v & 8'h1F;
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/pbri_ram.sv @@
// pbri_ram: generic single write port, single read port ram with registered read
// no dependencies

module pbri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/pbri_exec.sv @@
// pbri_exec: access execution stage; holds select, read latch, port registers,
// strobe and wait-state count, and issues sound register writes. uses pbri_pkg

module pbri_exec (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  pbri_pkg::req_t  item,
    input  pbri_pkg::cfg_t  cfg,
    input  logic [7:0]      ram_q,
    input  pbri_pkg::look_t look,
    output pbri_pkg::rsp_t  result,
    output pbri_pkg::wr_t   wr
);
    import pbri_pkg::*;

    logic [7:0] select_reg, select_next;
    logic [7:0] latch_reg, latch_next;
    logic [7:0] port_a_reg, port_a_next;
    logic [7:0] port_b_reg, port_b_next;
    logic       strobe_reg, strobe_next;
    logic [1:0] count_reg, count_next;

    logic             sel_ok;
    logic [IDX_W-1:0] sel_idx;
    logic             wd_ok;
    logic [IDX_W-1:0] wd_idx;
    logic [7:0]       lookup;
    logic [7:0]       nv;
    logic             skip;

    always_comb
    begin
        result      = '0;
        wr          = '0;
        select_next = select_reg;
        latch_next  = latch_reg;
        port_a_next = port_a_reg;
        port_b_next = port_b_reg;
        strobe_next = strobe_reg;
        count_next  = count_reg;

        sel_ok  = select_reg < REG_LIMIT;
        sel_idx = select_reg[IDX_W-1:0];
        wd_ok   = item.write_data < REG_LIMIT;
        wd_idx  = item.write_data[IDX_W-1:0];
        nv      = mask_value(sel_idx, item.write_data);

        // value a select load puts in the read latch
        if (!wd_ok)
        begin
            lookup = BYTE_ONES;
        end
        else if (wd_idx == PORT_A_IDX)
        begin
            lookup = port_a_reg;
        end
        else if (wd_idx == PORT_B_IDX)
        begin
            lookup = port_b_reg;
        end
        else if (look.fwd_hit)
        begin
            lookup = look.fwd_data;
        end
        else if (look.entry_valid)
        begin
            lookup = ram_q;
        end
        else
        begin
            lookup = '0;
        end

        // shadow write without byte access does nothing at all
        skip = (item.command == CMD_WRITE) && item.addr_offset[0] && !item.byte_access;

        if (!skip)
        begin
            if (item.new_instruction)
            begin
                result.wait_cycles = WAIT_STATES;
                count_next         = '0;
            end
            else if (item.is_movem)
            begin
                count_next = count_reg + 2'd1;
                if (count_next == '0)
                begin
                    result.wait_cycles = WAIT_STATES;
                end
            end

            if (item.command == CMD_READ)
            begin
                if (item.addr_offset == OFF_SELECT && sel_ok)
                begin
                    result.read_data = latch_reg;
                    // joystick overlays change the stored port, not the returned byte
                    if (sel_idx == PORT_A_IDX && cfg.joy_port2_enable)
                    begin
                        port_a_next[STROBE_BIT] = !item.joy2_data[7];
                    end
                    if (sel_idx == PORT_B_IDX)
                    begin
                        if (cfg.joy_port1_enable)
                        begin
                            port_b_next[7:4] = ~item.joy1_data[3:0];
                        end
                        if (cfg.joy_port2_enable)
                        begin
                            port_b_next[3:0] = ~item.joy2_data[3:0];
                        end
                    end
                end
                else
                begin
                    result.read_data = BYTE_ONES;
                end
            end
            else if (!item.addr_offset[1])
            begin
                select_next = item.write_data;
                latch_next  = lookup;
            end
            else if (sel_ok)
            begin
                latch_next = item.write_data;
                if (sel_idx < SOUND_COUNT)
                begin
                    wr.we              = fire;
                    wr.addr            = sel_idx;
                    wr.data            = nv;
                    result.sound_write = 1'b1;
                    result.sound_reg   = 4'(sel_idx);
                    result.sound_value = nv;
                end
                else if (sel_idx == PORT_A_IDX)
                begin
                    if (cfg.printer_enable && strobe_reg && !nv[STROBE_BIT])
                    begin
                        result.printer_valid = 1'b1;
                        result.printer_byte  = port_b_reg;
                    end
                    strobe_next           = nv[STROBE_BIT];
                    result.port_a_written = 1'b1;
                    result.drive_side_old = port_a_reg[2:0];
                    result.drive_side_new = nv[2:0];
                    result.dsp_rst_req    = cfg.dsp_report_enable && nv[DSP_BIT];
                    port_a_next           = nv;
                end
                else
                begin
                    port_b_next = nv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg <= '0;
            latch_reg  <= '0;
            port_a_reg <= PORT_A_RESET;
            port_b_reg <= '0;
            strobe_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (fire)
        begin
            select_reg <= select_next;
            latch_reg  <= latch_next;
            port_a_reg <= port_a_next;
            port_b_reg <= port_b_next;
            strobe_reg <= strobe_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/psg_bus_register_interface_top.sv @@
// psg_bus_register_interface_top: cpu bus register interface of a three-voice sound chip
// depends on pbri_pkg, pbri_ram, pbri_exec
//
//   channel | signals                          | beat content
//   --------+----------------------------------+------------------------------------
//   request | req_valid, req_stall, req        | one bus access (pbri_pkg::req_t)
//   result  | rsp_valid, rsp_stall, rsp        | one access result (pbri_pkg::rsp_t)
//   config  | cfg_write, cfg_index, cfg_data   | one 1-bit control register write
//
// every request beat gives exactly one result beat, through the execute stage register and
// the output register; one beat per cycle is sustained while the result side is not stalled
// request beats go through a ram read stage and an execute stage; the execute stage
// reads the sound register ram through its registered read port and writes it back
// reset clears control state and the valid bits of the ram at once; no clearing pass
// a stalled result holds the output register, then the execute stage, then the request

module psg_bus_register_interface_top (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  pbri_pkg::req_t               req,
    // result channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output pbri_pkg::rsp_t               rsp,
    // configuration port
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic                         cfg_data
);
    import pbri_pkg::*;

    // control registers
    cfg_t cfg_reg;

    // execute stage: item waiting for ram data
    logic  ex_valid_reg;
    req_t  ex_item_reg;
    look_t look_reg;

    // per-entry written marks; an unwritten sound register reads as zero
    logic [REG_COUNT-1:0] written_reg;

    // output register
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    logic       out_free;
    logic       ex_fire;
    logic       req_fire;
    logic [7:0] ram_q;
    rsp_t       ex_result;
    wr_t        wr;

    // handshake: the execute stage moves when the output register frees up
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign ex_fire   = ex_valid_reg && out_free;
    assign req_stall = ex_valid_reg && !out_free;
    assign req_fire  = req_valid && !req_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRINTER: cfg_reg.printer_enable    <= cfg_data;
                CFG_JOY1:    cfg_reg.joy_port1_enable  <= cfg_data;
                CFG_JOY2:    cfg_reg.joy_port2_enable  <= cfg_data;
                CFG_DSP:     cfg_reg.dsp_report_enable <= cfg_data;
                default:     cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // sound register ram; read issued as the beat is accepted, a possible
    // select load uses the data in the execute stage
    pbri_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (req_fire),
        .raddr (req.write_data[IDX_W-1:0]),
        .rdata (ram_q)
    );

    // ram read stage bookkeeping: forward a same-cycle write to the same entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            written_reg  <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (wr.we)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            ex_item_reg          <= req;
            look_reg.fwd_hit     <= wr.we && (wr.addr == req.write_data[IDX_W-1:0]);
            look_reg.fwd_data    <= wr.data;
            look_reg.entry_valid <= written_reg[req.write_data[IDX_W-1:0]];
        end
    end

    // execute stage
    pbri_exec u_exec (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (ex_fire),
        .item   (ex_item_reg),
        .cfg    (cfg_reg),
        .ram_q  (ram_q),
        .look   (look_reg),
        .result (ex_result),
        .wr     (wr)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= ex_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_fire)
        begin
            rsp_reg <= ex_result;
        end
    end

endmodule

@@ tb/tb_psg_bus_register_interface_top.sv @@
// tb_psg_bus_register_interface_top: self-checking bench for the sound chip bus register interface
// depends on pbri_pkg and psg_bus_register_interface_top; predicts every result beat in-bench
`timescale 1ns / 100ps

module tb_psg_bus_register_interface_top;

    import pbri_pkg::*;

    // offsets that the package does not name
    localparam logic [1:0] OFF_SEL_SHADOW  = 2'd1;
    localparam logic [1:0] OFF_DATA        = 2'd2;
    localparam logic [1:0] OFF_DATA_SHADOW = 2'd3;

    // second joystick fire button
    localparam int FIRE_BIT = 7;

    // bits kept per register on a data write, entry 15 down to entry 0
    localparam logic [15:0][7:0] KEEP_MASK = {
        8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF, 8'h1F, 8'h1F, 8'h1F,
        8'hFF, 8'h1F, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF
    };

    // cycles without any accepted beat before the run is declared hung
    localparam int HANG_LIMIT = 5000;
    // settle time after the last result
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ACCESSES = 180;
    localparam int MAX_PRINTED = 50;

    logic   clk;
    logic   rst_n;
    logic   req_valid;
    logic   req_stall;
    req_t   req;
    logic   rsp_valid;
    logic   rsp_stall;
    rsp_t   rsp;
    logic   cfg_write;
    logic [1:0] cfg_index;
    logic   cfg_data;

    psg_bus_register_interface_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // bus accesses waiting to be driven, and results still owed by the block
    req_t access_q[$];
    rsp_t result_q[$];

    int   send_idle_pct;
    int   rsp_stall_pct;
    logic req_taken;
    int   err_count;
    int   quiet_cycles;

    // shadow copy of the block: register file, select, read latch, strobe, burst count
    logic [7:0] regs_m [16];
    logic [7:0] sel_m;
    logic [7:0] latch_m;
    logic       strobe_m;
    logic [1:0] burst_cnt;

    // shadow copy of the control bits
    logic prn_en;
    logic joy1_en;
    logic joy2_en;
    logic dsp_en;

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string fname, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h want 0x%0h", fname, got, want));
    endtask

    task automatic compare_result(input rsp_t got, input rsp_t want);
        check_field("read_data",      got.read_data,          want.read_data);
        check_field("wait_cycles",    8'(got.wait_cycles),    8'(want.wait_cycles));
        check_field("sound_write",    8'(got.sound_write),    8'(want.sound_write));
        check_field("sound_reg",      8'(got.sound_reg),      8'(want.sound_reg));
        check_field("sound_value",    got.sound_value,        want.sound_value);
        check_field("printer_valid",  8'(got.printer_valid),  8'(want.printer_valid));
        check_field("printer_byte",   got.printer_byte,       want.printer_byte);
        check_field("port_a_written", 8'(got.port_a_written), 8'(want.port_a_written));
        check_field("drive_side_old", 8'(got.drive_side_old), 8'(want.drive_side_old));
        check_field("drive_side_new", 8'(got.drive_side_new), 8'(want.drive_side_new));
        check_field("dsp_rst_req",    8'(got.dsp_rst_req),    8'(want.dsp_rst_req));
    endtask

    task automatic reset_shadow();
        for (int i = 0; i < REG_COUNT; i++)
            regs_m[i] = 8'h00;
        regs_m[PORT_A_IDX] = PORT_A_RESET;
        sel_m     = 8'h00;
        latch_m   = 8'h00;
        strobe_m  = 1'b0;
        burst_cnt = 2'd0;
        prn_en    = 1'b0;
        joy1_en   = 1'b0;
        joy2_en   = 1'b0;
        dsp_en    = 1'b0;
    endtask

    // wait states: a new instruction always pays, a multi-register move pays every fourth beat
    function automatic logic [2:0] charge_wait(input logic first, input logic multi);
        if (first)
        begin
            burst_cnt = 2'd0;
            return WAIT_STATES;
        end
        if (multi)
        begin
            burst_cnt = burst_cnt + 2'd1;
            if (burst_cnt == 2'd0)
                return WAIT_STATES;
        end
        return 3'd0;
    endfunction

    // expected result of one accepted access; updates the shadow state
    function automatic rsp_t predict_access(input req_t a);
        rsp_t       r;
        logic [3:0] idx;
        logic [7:0] prev;
        logic [7:0] stored;
        r   = '0;
        idx = sel_m[3:0];
        if (a.command == CMD_READ)
        begin
            r.wait_cycles = charge_wait(a.new_instruction, a.is_movem);
            if (a.addr_offset != OFF_SELECT || sel_m >= REG_LIMIT)
            begin
                r.read_data = BYTE_ONES;
                return r;
            end
            // joystick overlays land in the stored port, the latch is returned as is
            if (idx == PORT_A_IDX && joy2_en)
                regs_m[PORT_A_IDX][STROBE_BIT] = ~a.joy2_data[FIRE_BIT];
            if (idx == PORT_B_IDX && joy1_en)
                regs_m[PORT_B_IDX][7:4] = ~a.joy1_data[3:0];
            if (idx == PORT_B_IDX && joy2_en)
                regs_m[PORT_B_IDX][3:0] = ~a.joy2_data[3:0];
            r.read_data = latch_m;
            return r;
        end
        // shadow offsets only take byte accesses, anything else is dropped silently
        if (a.addr_offset[0] && !a.byte_access)
            return r;
        r.wait_cycles = charge_wait(a.new_instruction, a.is_movem);
        if (!a.addr_offset[1])
        begin
            sel_m   = a.write_data;
            latch_m = (a.write_data < REG_LIMIT) ? regs_m[a.write_data[3:0]] : BYTE_ONES;
        end
        else if (sel_m < REG_LIMIT)
        begin
            latch_m      = a.write_data;
            prev         = regs_m[idx];
            stored       = a.write_data & KEEP_MASK[idx];
            regs_m[idx]  = stored;
            if (idx < SOUND_COUNT)
            begin
                r.sound_write = 1'b1;
                r.sound_reg   = idx;
                r.sound_value = stored;
            end
            else if (idx == PORT_A_IDX)
            begin
                // falling strobe sends port B out
                if (prn_en && strobe_m && !stored[STROBE_BIT])
                begin
                    r.printer_valid = 1'b1;
                    r.printer_byte  = regs_m[PORT_B_IDX];
                end
                strobe_m         = stored[STROBE_BIT];
                r.port_a_written = 1'b1;
                r.drive_side_old = prev[2:0];
                r.drive_side_new = stored[2:0];
                r.dsp_rst_req    = dsp_en && stored[DSP_BIT];
            end
        end
        return r;
    endfunction

    function automatic req_t mk_access(input logic cmd, input logic [1:0] off,
                                       input logic byte_acc, input logic [7:0] wd,
                                       input logic first, input logic multi,
                                       input logic [7:0] j1, input logic [7:0] j2);
        req_t a;
        a.command         = cmd;
        a.addr_offset     = off;
        a.byte_access     = byte_acc;
        a.write_data      = wd;
        a.new_instruction = first;
        a.is_movem        = multi;
        a.joy1_data       = j1;
        a.joy2_data       = j2;
        return a;
    endfunction

    // register index biased toward the ports, sometimes out of range
    function automatic logic [7:0] pick_select();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return 8'(PORT_A_IDX);
        if (roll < 45)
            return 8'(PORT_B_IDX);
        if (roll < 90)
            return 8'($urandom_range(13));
        return 8'($urandom_range(255, 16));
    endfunction

    // mostly well-formed select / data / read traffic, the rest pure noise
    function automatic req_t random_access();
        req_t a;
        int   roll;
        a    = req_t'($bits(req_t)'($urandom));
        roll = $urandom_range(99);
        a.new_instruction = ($urandom_range(9) < 4);
        if (roll < 15)
            return a;
        if (roll < 50)
        begin
            a.command     = CMD_WRITE;
            a.addr_offset = $urandom_range(1) ? OFF_SEL_SHADOW : OFF_SELECT;
            a.byte_access = (a.addr_offset == OFF_SEL_SHADOW) ? 1'b1 : a.byte_access;
            a.write_data  = pick_select();
        end
        else if (roll < 80)
        begin
            a.command     = CMD_WRITE;
            a.addr_offset = $urandom_range(1) ? OFF_DATA_SHADOW : OFF_DATA;
            a.byte_access = (a.addr_offset == OFF_DATA_SHADOW) ? 1'b1 : a.byte_access;
        end
        else
        begin
            a.command     = CMD_READ;
            a.addr_offset = ($urandom_range(9) < 8) ? OFF_SELECT : 2'($urandom_range(3));
        end
        return a;
    endfunction

    // one control register write, applied at the next rising edge
    task automatic write_ctrl(input cfg_idx_t which, input logic val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val;
        case (which)
            CFG_PRINTER: prn_en  = val;
            CFG_JOY1:    joy1_en = val;
            CFG_JOY2:    joy2_en = val;
            CFG_DSP:     dsp_en  = val;
            default: ;
        endcase
    endtask

    // bits: printer, joystick 1, joystick 2, dsp report
    task automatic set_controls(input logic [3:0] bits);
        write_ctrl(CFG_PRINTER, bits[3]);
        write_ctrl(CFG_JOY1,    bits[2]);
        write_ctrl(CFG_JOY2,    bits[1]);
        write_ctrl(CFG_DSP,     bits[0]);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // block until every queued access went out and every result came back, then settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (access_q.size() != 0 || req_valid || result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // driver: new beat only when the line is free or the current beat was taken
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= access_q.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
        rsp_stall <= rst_n && ($urandom_range(99) < rsp_stall_pct);
    end

    // monitor: check result beats, predict accepted request beats, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (result_q.size() == 0)
                    report_error("result beat with no access outstanding");
                else
                    compare_result(rsp, result_q.pop_front());
            end
            if (req_valid && !req_stall)
                result_q.push_back(predict_access(req));
            req_taken <= req_valid && !req_stall;

            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("ERROR: no beat accepted for %0d cycles", HANG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [3:0] ctl;
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_PRINTER;
        cfg_data      = 1'b0;
        req_taken     = 1'b0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        err_count     = 0;
        quiet_cycles  = 0;
        reset_shadow();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed part runs with every control bit on
        set_controls(4'b1111);

        // read after reset, then port A strobe rise and fall with printer on
        access_q.push_back(mk_access(CMD_READ,  OFF_SELECT, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_SELECT, 1'b0, 8'(PORT_A_IDX),
                                     1'b1, 1'b0, 8'hFF, 8'hFF));
        access_q.push_back(mk_access(CMD_WRITE, OFF_DATA,   1'b0, 8'h20, 1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_DATA,   1'b0, 8'h17, 1'b1, 1'b0, 8'h00, 8'h00));
        // fire released sets port A bit 5, seen only after the next select
        access_q.push_back(mk_access(CMD_READ,  OFF_SELECT, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_SELECT, 1'b0, 8'(PORT_A_IDX),
                                     1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_READ,  OFF_SELECT, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h80));
        // port B write and both joystick overlays
        access_q.push_back(mk_access(CMD_WRITE, OFF_SELECT, 1'b0, 8'(PORT_B_IDX),
                                     1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_DATA,   1'b0, 8'hA5, 1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_READ,  OFF_SELECT, 1'b0, 8'h00, 1'b1, 1'b0, 8'h0C, 8'h03));
        access_q.push_back(mk_access(CMD_WRITE, OFF_SELECT, 1'b0, 8'(PORT_B_IDX),
                                     1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_READ,  OFF_SELECT, 1'b0, 8'h00, 1'b1, 1'b0, 8'hFF, 8'hFF));
        // select just past the file, and the top byte value
        access_q.push_back(mk_access(CMD_WRITE, OFF_SELECT, 1'b0, 8'h10, 1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_DATA,   1'b0, 8'h55, 1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_READ,  OFF_SELECT, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_SELECT, 1'b0, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_READ,  OFF_SEL_SHADOW, 1'b1, 8'h00,
                                     1'b1, 1'b0, 8'h00, 8'h00));
        // shadow writes with and without byte access, inside a multi-register move
        access_q.push_back(mk_access(CMD_WRITE, OFF_SEL_SHADOW, 1'b0, 8'h03,
                                     1'b0, 1'b1, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_SEL_SHADOW, 1'b1, 8'h01,
                                     1'b0, 1'b1, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_DATA_SHADOW, 1'b1, 8'hFF,
                                     1'b0, 1'b1, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_DATA_SHADOW, 1'b0, 8'h00,
                                     1'b0, 1'b1, 8'h00, 8'h00));
        // five-bit register masks, then the unmasked byte comes back from the latch
        access_q.push_back(mk_access(CMD_WRITE, OFF_SELECT, 1'b0, 8'h06, 1'b0, 1'b1, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_WRITE, OFF_DATA,   1'b0, 8'hFF, 1'b0, 1'b1, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_READ,  OFF_SELECT, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00));
        access_q.push_back(mk_access(CMD_READ,  OFF_DATA,   1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00));
        wait_drained();

        // random phases: control settings cycle, idling pattern rotates
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: ctl = 4'b0000;
                1: ctl = 4'b1111;
                2: ctl = 4'b1010;
                3: ctl = 4'b0101;
                4: ctl = 4'b1100;
                5: ctl = 4'b0011;
                6: ctl = 4'b1001;
                default: ctl = 4'($urandom_range(15));
            endcase
            set_controls(ctl);
            case (p % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 63; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 63; end
                default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
            endcase
            for (int k = 0; k < PHASE_ACCESSES; k++)
            begin
                access_q.push_back(random_access());
                // mid-phase hold: sender stops until every owed result is back
                if (p == 2 && k == PHASE_ACCESSES / 2)
                    wait_drained();
            end
            wait_drained();
        end

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
